@@ sv/ifsp_pkg.sv @@
// shared types, constants and helpers of the ipv4 fragment size planner
package ifsp_pkg;

  localparam int unsigned HeaderBytes  = 20;
  localparam int unsigned MaxFragments = 64;
  localparam int unsigned FifoDepth    = 2;
  localparam int unsigned DivSteps     = 16;

  localparam int unsigned CntW   = $clog2(MaxFragments);
  localparam int unsigned NfragW = $clog2(MaxFragments + 1);
  localparam int unsigned DivCntW = $clog2(DivSteps);

  localparam logic [15:0] MtuFloor = 16'd1048;
  localparam logic [15:0] MtuReset = 16'd1500;
  localparam logic [15:0] HdrLen   = 16'(HeaderBytes);

  // one packet waiting for the back end
  typedef struct packed {
    logic        unfrag;
    logic [15:0] total;
    logic [15:0] len;
  } job_t;

  typedef struct packed {
    logic        start;
    logic [15:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quot;
    logic [15:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_CNT,
    ST_DIV_AVG,
    ST_MUL,
    ST_FIRST,
    ST_EMIT
  } back_state_e;

  function automatic logic [15:0] round_up8(input logic [15:0] v);
    logic [16:0] s;
    s = {1'b0, v} + 17'd7;
    return {s[15:3], 3'b000};
  endfunction

endpackage

@@ sv/ifsp_fifo.sv @@
// short job queue between the front and back ends
module ifsp_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ifsp_pkg::job_t push_data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output ifsp_pkg::job_t head_o
);
  import ifsp_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FillW = $clog2(FifoDepth + 1);

  job_t             mem_q [FifoDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FillW-1:0] fill_q, fill_d;
  logic             do_push, do_pop;

  assign full_o  = (fill_q == FillW'(FifoDepth));
  assign empty_o = (fill_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(FifoDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_comb begin
    wr_ptr_d = do_push ? next_ptr(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_pop ? next_ptr(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + FillW'(1);
    end else if (do_pop && !do_push) begin
      fill_d = fill_q - FillW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ sv/ifsp_front.sv @@
// front end: mtu register, input accept and fits-or-fragments classification
module ifsp_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [15:0]    cfg_wdata_i,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  logic [15:0]    packet_length_i,
  input  logic           fifo_full_i,
  output logic           push_o,
  output ifsp_pkg::job_t job_o,
  output logic [15:0]    mtu_o
);
  import ifsp_pkg::*;

  logic [15:0] mtu_q, mtu_d;

  always_comb begin
    mtu_d = mtu_q;
    if (cfg_we_i) begin
      mtu_d = (cfg_wdata_i < MtuFloor) ? MtuFloor : cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtu_q <= MtuReset;
    end else begin
      mtu_q <= mtu_d;
    end
  end

  assign mtu_o      = mtu_q;
  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  // a length below the header always fits, so the payload clamp only hits whole packets
  always_comb begin
    job_o.unfrag = (packet_length_i <= mtu_q);
    job_o.total  = packet_length_i;
    job_o.len    = (packet_length_i >= HdrLen) ? packet_length_i - HdrLen : '0;
  end

endmodule

@@ sv/ifsp_div.sv @@
// bit-serial restoring divider, one quotient bit per cycle
module ifsp_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ifsp_pkg::div_req_t req_i,
  output ifsp_pkg::div_rsp_t rsp_o
);
  import ifsp_pkg::*;

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [15:0]        rem_q, rem_d;
  logic [15:0]        quot_q, quot_d;
  logic [15:0]        dvs_q, dvs_d;
  logic [16:0]        shifted;
  logic               fits;

  assign shifted = {rem_q, quot_q[15]};
  assign fits    = (shifted >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DivCntW'(DivSteps - 1);
      rem_d  = '0;
      quot_d = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d  = fits ? 16'(shifted - {1'b0, dvs_q}) : shifted[15:0];
      quot_d = {quot_q[14:0], fits};
      cnt_d  = cnt_q - DivCntW'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q;

endmodule

@@ sv/ifsp_back.sv @@
// back end: sizes one packet's fragments, emits one per cycle unless stalled
module ifsp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [15:0]        mtu_i,
  input  logic               fifo_empty_i,
  input  ifsp_pkg::job_t     head_i,
  output logic               pop_o,
  output ifsp_pkg::div_req_t div_req_o,
  input  ifsp_pkg::div_rsp_t div_rsp_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [15:0]        payload_offset_o,
  output logic [15:0]        payload_length_o,
  output logic               more_fragments_o,
  output logic [13:0]        fragment_word_o,
  output logic [15:0]        fragment_total_length_o,
  output logic               unfragmented_o,
  output logic               last_o
);
  import ifsp_pkg::*;

  back_state_e        state_q, state_d;
  job_t               job_q;
  logic [NfragW-1:0]  nfrag_q;
  logic [15:0]        fleno_q;
  logic [15:0]        flen0_q;
  logic [22:0]        prod_q;
  logic               fixed_q;
  logic [15:0]        off_q;
  logic [CntW-1:0]    cnt_q;

  logic               out_valid_q;
  logic [15:0]        out_off_q, out_len_q, out_total_q;
  logic               out_mf_q, out_unfrag_q, out_last_q;

  logic [15:0]        unit_room, fmtu;
  logic [NfragW-1:0]  nfrag_calc;
  logic [15:0]        first_raw;
  logic               first_over;
  logic [15:0]        rest, flen;
  logic               mf, fin;
  logic               load;

  assign unit_room  = mtu_i - HdrLen;
  assign fmtu       = {unit_room[15:3], 3'b000};
  assign nfrag_calc = div_rsp_i.quot[NfragW-1:0] + NfragW'(div_rsp_i.rem != '0);
  assign first_raw  = round_up8(job_q.len - prod_q[15:0]);
  assign first_over = (first_raw > fmtu);

  // size of the fragment at the current offset
  always_comb begin
    rest = job_q.len - off_q;
    flen = rest;
    if (rest > unit_room) begin
      flen = (off_q == '0) ? flen0_q : fleno_q;
    end
    if (flen > rest || flen == '0) begin
      flen = rest;
    end
    mf  = (flen < rest);
    fin = !mf || (cnt_q == CntW'(MaxFragments - 1));
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = head_i.unfrag ? ST_EMIT : ST_DIV_CNT;
        end
      end
      ST_DIV_CNT: begin
        if (div_rsp_i.done) begin
          state_d = ST_DIV_AVG;
        end
      end
      ST_DIV_AVG: begin
        if (div_rsp_i.done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL: state_d = ST_FIRST;
      ST_FIRST: begin
        state_d = (first_over && !fixed_q) ? ST_MUL : ST_EMIT;
      end
      ST_EMIT: begin
        if (load && fin) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o     = 1'b0;
    div_req_o = '0;
    load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        pop_o              = !fifo_empty_i;
        div_req_o.start    = !fifo_empty_i && !head_i.unfrag;
        div_req_o.dividend = head_i.len;
        div_req_o.divisor  = fmtu;
      end
      ST_DIV_CNT: begin
        div_req_o.start    = div_rsp_i.done;
        div_req_o.dividend = job_q.len;
        div_req_o.divisor  = 16'(nfrag_calc);
      end
      ST_EMIT: load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q   <= head_i;
      fixed_q <= 1'b0;
      off_q   <= '0;
      cnt_q   <= '0;
    end
    if (state_q == ST_DIV_CNT && div_rsp_i.done) begin
      nfrag_q <= nfrag_calc;
    end
    if (state_q == ST_DIV_AVG && div_rsp_i.done) begin
      fleno_q <= {div_rsp_i.quot[15:3], 3'b000};
    end
    if (state_q == ST_MUL) begin
      prod_q <= 23'(fleno_q) * 23'(nfrag_q - NfragW'(1));
    end
    if (state_q == ST_FIRST) begin
      // one widening of the middle size if the first fragment would overflow
      if (first_over && !fixed_q) begin
        fleno_q <= fleno_q + 16'd8;
        fixed_q <= 1'b1;
      end else begin
        flen0_q <= (first_raw < fleno_q) ? fleno_q : first_raw;
      end
    end
    if (load) begin
      off_q        <= off_q + flen;
      cnt_q        <= cnt_q + CntW'(1);
      out_off_q    <= off_q;
      out_len_q    <= flen;
      out_mf_q     <= mf;
      out_total_q  <= job_q.unfrag ? job_q.total : flen + HdrLen;
      out_unfrag_q <= job_q.unfrag;
      out_last_q   <= fin;
    end
  end

  assign out_valid_o             = out_valid_q;
  assign payload_offset_o        = out_off_q;
  assign payload_length_o        = out_len_q;
  assign more_fragments_o        = out_mf_q;
  assign fragment_word_o         = {out_mf_q, out_off_q[15:3]};
  assign fragment_total_length_o = out_total_q;
  assign unfragmented_o          = out_unfrag_q;
  assign last_o                  = out_last_q;

endmodule

@@ sv/ipv4_fragment_size_planner_core.sv @@
// a packet that fits the mtu goes from the queue via the emit state to the output
// a fragmented packet runs two 16-step bit-serial divisions, then the mul and first
// sizing states, twice if the middle size must widen; then its fragments leave one
// per cycle while the output is not stalled
// a two-entry queue lets new packets in while the back end works
// reset: mtu is 1500, the queue and the output register are empty
module ipv4_fragment_size_planner_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] packet_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] payload_offset_o,
  output logic [15:0] payload_length_o,
  output logic        more_fragments_o,
  output logic [13:0] fragment_word_o,
  output logic [15:0] fragment_total_length_o,
  output logic        unfragmented_o,
  output logic        last_o
);
  import ifsp_pkg::*;

  job_t        push_job, head_job;
  logic        push, pop, fifo_full, fifo_empty;
  logic [15:0] mtu;
  div_req_t    div_req;
  div_rsp_t    div_rsp;

  ifsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .packet_length_i (packet_length_i),
    .fifo_full_i     (fifo_full),
    .push_o          (push),
    .job_o           (push_job),
    .mtu_o           (mtu)
  );

  ifsp_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .empty_o     (fifo_empty),
    .head_o      (head_job)
  );

  ifsp_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ifsp_back u_back (
    .clk_i                   (clk_i),
    .rst_ni                  (rst_ni),
    .mtu_i                   (mtu),
    .fifo_empty_i            (fifo_empty),
    .head_i                  (head_job),
    .pop_o                   (pop),
    .div_req_o               (div_req),
    .div_rsp_i               (div_rsp),
    .out_valid_o             (out_valid_o),
    .out_stall_i             (out_stall_i),
    .payload_offset_o        (payload_offset_o),
    .payload_length_o        (payload_length_o),
    .more_fragments_o        (more_fragments_o),
    .fragment_word_o         (fragment_word_o),
    .fragment_total_length_o (fragment_total_length_o),
    .unfragmented_o          (unfragmented_o),
    .last_o                  (last_o)
  );

endmodule

@@ sv/ifsp_checker.sv @@
// port-level checks of the planner and their binding to the top level
module ifsp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [15:0] payload_offset_i,
  input logic [15:0] payload_length_i,
  input logic        more_fragments_i,
  input logic [13:0] fragment_word_i,
  input logic [15:0] fragment_total_length_i,
  input logic        unfragmented_i,
  input logic        last_i
);

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i && $stable(payload_offset_i)
      && $stable(payload_length_i) && $stable(last_i))
    else $error("stalled output item changed");

  a_whole_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && unfragmented_i |-> last_i && !more_fragments_i
      && payload_offset_i == 16'd0 && fragment_word_i == 14'd0)
    else $error("unfragmented item is not a single final item");

  a_frag_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !unfragmented_i |->
      fragment_total_length_i == 16'(payload_length_i + 16'd20)
      && fragment_word_i[13] == more_fragments_i
      && fragment_word_i[12:0] == payload_offset_i[15:3])
    else $error("fragment header fields disagree");

  a_final_frag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !unfragmented_i && !more_fragments_i |-> last_i)
    else $error("fragment without more flag is not marked last");

  // the item after a non-final fragment starts where it ended
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_stall_i && !last_i ##1 out_valid_i |->
      payload_offset_i == 16'($past(payload_offset_i) + $past(payload_length_i)))
    else $error("fragment offsets are not contiguous");

endmodule

bind ipv4_fragment_size_planner_core ifsp_checker u_ifsp_checker (
  .clk_i                   (clk_i),
  .rst_ni                  (rst_ni),
  .out_valid_i             (out_valid_o),
  .out_stall_i             (out_stall_i),
  .payload_offset_i        (payload_offset_o),
  .payload_length_i        (payload_length_o),
  .more_fragments_i        (more_fragments_o),
  .fragment_word_i         (fragment_word_o),
  .fragment_total_length_i (fragment_total_length_o),
  .unfragmented_i          (unfragmented_o),
  .last_i                  (last_o)
);

@@ tb/sv/tb_ipv4_fragment_size_planner_core.sv @@
// self-checking testbench of the ipv4 fragment size planner core
module tb_ipv4_fragment_size_planner_core;
  timeunit 1ns;
  timeprecision 1ps;
  import ifsp_pkg::*;

  localparam int unsigned MfFlag    = 'h2000;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned HoldPhase = 3;
  localparam int unsigned HoldCycles = 400;

  typedef struct packed {
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic        more_frags;
    logic [13:0] frag_word;
    logic [15:0] total_length;
    logic        unfrag;
    logic        last_frag;
  } frag_item_t;

  // plans the fragments of each accepted packet and holds them until they leave the block
  class fragment_ledger;
    frag_item_t  planned[$];
    int unsigned mtu_bytes;
    int          mismatches;

    function new();
      mtu_bytes  = MtuReset;
      mismatches = 0;
    endfunction

    function void set_mtu(logic [15:0] v);
      mtu_bytes = (v < MtuFloor) ? MtuFloor : v;
    endfunction

    function int unsigned align8(int unsigned v);
      return (v + 7) & ~32'd7;
    endfunction

    function void note_packet(logic [15:0] pkt_len);
      int unsigned plen, len, room, unit, nfrag, fleno, flen0, off, rest, flen, cnt;
      frag_item_t  f;
      plen = pkt_len;
      if (plen <= mtu_bytes) begin
        f.payload_offset = '0;
        f.payload_length = (plen >= HeaderBytes) ? 16'(plen - HeaderBytes) : '0;
        f.more_frags     = 1'b0;
        f.frag_word      = '0;
        f.total_length   = 16'(plen);
        f.unfrag         = 1'b1;
        f.last_frag      = 1'b1;
        planned.push_back(f);
        return;
      end
      len   = plen - HeaderBytes;
      room  = mtu_bytes - HeaderBytes;
      unit  = room & ~32'd7;
      nfrag = (len + unit - 1) / unit;
      fleno = (len / nfrag) & ~32'd7;
      flen0 = align8(len - fleno * (nfrag - 1));
      // first chunk too big for the unit: grow the medium size by one step
      if (flen0 > unit) begin
        fleno += 8;
        flen0 = align8(len - fleno * (nfrag - 1));
      end
      if (flen0 < fleno) flen0 = fleno;
      off = 0;
      cnt = 0;
      while (off < len && cnt < MaxFragments) begin
        rest = len - off;
        flen = rest;
        if (rest > room) flen = (off == 0) ? flen0 : fleno;
        if (flen > rest) flen = rest;
        if (flen == 0) flen = rest;
        f.payload_offset = 16'(off);
        f.payload_length = 16'(flen);
        f.more_frags     = (flen < rest);
        f.frag_word      = 14'((off >> 3) | (f.more_frags ? MfFlag : 0));
        f.total_length   = 16'(flen + HeaderBytes);
        f.unfrag         = 1'b0;
        f.last_frag      = !f.more_frags || (cnt == MaxFragments - 1);
        planned.push_back(f);
        cnt++;
        off += flen;
      end
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
        mismatches++;
      end
    endfunction

    function void check_fragment(frag_item_t got);
      frag_item_t want;
      if (planned.size() == 0) begin
        $display("%0t: unexpected item offset %0d length %0d", $time,
                 got.payload_offset, got.payload_length);
        mismatches++;
        return;
      end
      want = planned.pop_front();
      compare("payload_offset", want.payload_offset, got.payload_offset);
      compare("payload_length", want.payload_length, got.payload_length);
      compare("more_fragments", want.more_frags, got.more_frags);
      compare("fragment_word", want.frag_word, got.frag_word);
      compare("fragment_total_length", want.total_length, got.total_length);
      compare("unfragmented", want.unfrag, got.unfrag);
      compare("last", want.last_frag, got.last_frag);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [15:0] packet_length_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] payload_offset_o;
  logic [15:0] payload_length_o;
  logic        more_fragments_o;
  logic [13:0] fragment_word_o;
  logic [15:0] fragment_total_length_o;
  logic        unfragmented_o;
  logic        last_o;

  fragment_ledger ledger;
  int  idle_pct   = 0;
  int  stall_pct  = 0;
  bit  want_hold  = 1'b0;
  bit  hold_done  = 1'b0;
  int  stall_left = 0;

  ipv4_fragment_size_planner_core u_top (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_we_i               (cfg_we_i),
    .cfg_wdata_i            (cfg_wdata_i),
    .in_valid_i             (in_valid_i),
    .in_stall_o             (in_stall_o),
    .packet_length_i        (packet_length_i),
    .out_valid_o            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .payload_offset_o       (payload_offset_o),
    .payload_length_o       (payload_length_o),
    .more_fragments_o       (more_fragments_o),
    .fragment_word_o        (fragment_word_o),
    .fragment_total_length_o(fragment_total_length_o),
    .unfragmented_o         (unfragmented_o),
    .last_o                 (last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // offer one packet, hold it until taken, then maybe leave a gap
  task automatic send_packet(logic [15:0] pkt_len);
    in_valid_i      <= 1'b1;
    packet_length_i <= pkt_len;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    ledger.note_packet(pkt_len);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic drain_block();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (ledger.planned.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_mtu(logic [15:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    ledger.set_mtu(v);
  endtask

  // lengths around the mtu, around fragment unit multiples, tiny and huge
  function automatic logic [15:0] pick_length(int unsigned mtu);
    int unsigned unit, v;
    unit = (mtu - HeaderBytes) & ~32'd7;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 65535);
      1: v = mtu + $urandom_range(0, 48) - 24;
      2: v = $urandom_range(1, 64) * unit + HeaderBytes + $urandom_range(0, 16) - 8;
      3: v = $urandom_range(0, mtu);
      4: v = $urandom_range(60000, 65535);
      default: v = $urandom_range(0, 65535);
    endcase
    if (v > 65535) v = 65535;
    return v[15:0];
  endfunction

  always @(posedge clk_i) begin : rx_side
    frag_item_t got;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        got.payload_offset = payload_offset_o;
        got.payload_length = payload_length_o;
        got.more_frags     = more_fragments_o;
        got.frag_word      = fragment_word_o;
        got.total_length   = fragment_total_length_o;
        got.unfrag         = unfragmented_o;
        got.last_frag      = last_o;
        ledger.check_fragment(got);
      end
      if (stall_left > 0) stall_left--;
      else if (want_hold && !hold_done) begin
        // long hold so the input queue fills and the block pushes back
        stall_left = HoldCycles;
        hold_done  = 1'b1;
      end else if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 12);
      out_stall_i <= (stall_left > 0);
    end
  end

  initial begin
    logic [15:0] corner_lengths[] = '{16'd0, 16'd1, 16'd19, 16'd20, 16'd21, 16'd1499,
                                      16'd1500, 16'd1501, 16'd1519, 16'd1520, 16'd1521,
                                      16'd2000, 16'd2960, 16'd2961, 16'd2980, 16'd2981,
                                      16'd4000, 16'd10000, 16'd32768, 16'h5555, 16'haaaa,
                                      16'd65534, 16'd65535};
    logic [15:0] mtu_plan[NumPhases] = '{16'd0, 16'd65535, 16'd1048, 16'd1047, 16'd1049,
                                         16'd9000, 16'd0, 16'd1500, 16'd0, 16'd1280};
    ledger = new();
    mtu_plan[6] = $urandom_range(0, 65535);
    mtu_plan[8] = $urandom_range(1000, 4000);
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct  = 20;
    stall_pct = 20;
    foreach (corner_lengths[i]) send_packet(corner_lengths[i]);
    for (int p = 0; p < NumPhases; p++) begin
      drain_block();
      write_mtu(mtu_plan[p]);
      case (p % 3)
        0: begin idle_pct = 15; stall_pct = 15; end
        1: begin idle_pct = 40; stall_pct = 5; end
        default: begin idle_pct = 0; stall_pct = 30; end
      endcase
      if (p == NumPhases - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end
      if (p == HoldPhase) want_hold = 1'b1;
      send_packet(16'(ledger.mtu_bytes - 1));
      send_packet(16'(ledger.mtu_bytes));
      if (ledger.mtu_bytes < 65535) send_packet(16'(ledger.mtu_bytes + 1));
      repeat (28) send_packet(pick_length(ledger.mtu_bytes));
    end
    drain_block();
    repeat (20) @(posedge clk_i);
    if (ledger.mismatches == 0 && ledger.planned.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
